// File: sv/ftn_pkg.sv
// Shared types, constants and functions for the frequency-to-note converter.
`default_nettype none

package ftn_pkg;

	// Field widths
	localparam int FREQ_W     = 22;
	localparam int REF_W      = 18;
	localparam int LOG_INT_W  = 5;
	localparam int LOG_FRAC_W = 16;
	localparam int LOG_W      = LOG_INT_W + LOG_FRAC_W;
	localparam int MANT_W     = 31;
	localparam int IDX_W      = 8;
	localparam int PC_W       = 4;
	localparam int OCT_W      = 4;
	localparam int MIDI_W     = 8;
	localparam int CENTS_W    = 7;

	// Musical constants
	localparam int A4_INDEX        = 57;
	localparam int SEMITONES       = 12;
	localparam int CENTS_PER_SEMI  = 100;
	localparam int HALF_SEMI_CENTS = 50;

	// Defaults
	localparam logic [REF_W-1:0] REF_RESET = 18'd112640;
	localparam int TOP_OCTAVE_DEF = 9;

	// One log2 word in flight: integer part, fraction so far, Q30 mantissa
	typedef struct packed {
		logic                  valid;
		logic                  zero;
		logic [LOG_INT_W-1:0]  ipart;
		logic [LOG_FRAC_W-1:0] frac;
		logic [MANT_W-1:0]     mant;
	} log_t;

	// Result of normalising a value to [1,2) in Q30
	typedef struct packed {
		logic                 zero;
		logic [LOG_INT_W-1:0] ipart;
		logic [MANT_W-1:0]    mant;
	} norm_t;

	typedef enum logic [1:0] {
		REF_IDLE,
		REF_NORM,
		REF_SQUARE
	} ref_state_t;

	// Leading-one position and mantissa aligned so the top set bit sits at bit 30
	function automatic norm_t normalise(input logic [FREQ_W-1:0] x);
		logic [LOG_INT_W-1:0] p;
		logic [FREQ_W+MANT_W-2:0] w;
		norm_t r;
		p = '0;
		for (int i = 0; i < FREQ_W; i++) begin
			if (x[i]) begin
				p = LOG_INT_W'(i);
			end
		end
		w = {{(MANT_W-1){1'b0}}, x} << (LOG_INT_W'(MANT_W - 1) - p);
		r.zero  = (x == '0);
		r.ipart = p;
		r.mant  = w[MANT_W-1:0];
		return r;
	endfunction

	// Square of a Q30 mantissa, truncated back to Q30 (may reach 2.0 or more)
	function automatic logic [MANT_W:0] square_q30(input logic [MANT_W-1:0] m);
		logic [2*MANT_W-1:0] prod;
		prod = {{MANT_W{1'b0}}, m} * {{MANT_W{1'b0}}, m};
		return prod[2*MANT_W-1:MANT_W-1];
	endfunction

endpackage

`default_nettype wire

// File: sv/ftn_log2_iter.sv
// Reference pitch register and its iterative log2 unit, one squaring per cycle.
`default_nettype none

module ftn_log2_iter (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [ftn_pkg::REF_W-1:0]     reference_pitch,
	output logic                               busy,
	output logic [ftn_pkg::LOG_W-1:0]          log_ref,
	output logic                               ref_zero
);
	import ftn_pkg::*;

	ref_state_t               state_q, state_nxt;
	logic [REF_W-1:0]         ref_q;
	logic [3:0]               bit_q;
	logic [LOG_INT_W-1:0]     ipart_q;
	logic [LOG_FRAC_W-1:0]    frac_q;
	logic [MANT_W-1:0]        mant_q;
	logic                     zero_q;
	norm_t                    norm;
	logic [MANT_W:0]          sq;
	logic                     cfg_fire;

	assign norm     = normalise({{(FREQ_W-REF_W){1'b0}}, ref_q});
	assign sq       = square_q30(mant_q);
	assign cfg_fire = cfg_valid && cfg_ready;

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			REF_IDLE:   if (cfg_fire) state_nxt = REF_NORM;
			REF_NORM:   state_nxt = REF_SQUARE;
			REF_SQUARE: if (bit_q == '0) state_nxt = REF_IDLE;
			default:    state_nxt = REF_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cfg_ready = 1'b0;
		busy      = 1'b1;
		case (state_q)
			REF_IDLE: begin
				cfg_ready = 1'b1;
				busy      = 1'b0;
			end
			default: begin
				cfg_ready = 1'b0;
				busy      = 1'b1;
			end
		endcase
	end

	// Control state and the register itself; reset starts a log2 of the default
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= REF_NORM;
			ref_q   <= REF_RESET;
			bit_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (cfg_fire) begin
				ref_q <= reference_pitch;
			end
			if (state_q == REF_NORM) begin
				bit_q <= 4'(LOG_FRAC_W - 1);
			end else if (state_q == REF_SQUARE) begin
				bit_q <= bit_q - 4'd1;
			end
		end
	end

	// Datapath: normalise, then one fraction bit per squaring
	always_ff @(posedge clk) begin
		if (state_q == REF_NORM) begin
			ipart_q <= norm.ipart;
			mant_q  <= norm.mant;
			zero_q  <= norm.zero;
			frac_q  <= '0;
		end else if (state_q == REF_SQUARE) begin
			if (sq[MANT_W]) begin
				mant_q        <= sq[MANT_W:1];
				frac_q[bit_q] <= 1'b1;
			end else begin
				mant_q <= sq[MANT_W-1:0];
			end
		end
	end

	assign log_ref  = {ipart_q, frac_q};
	assign ref_zero = zero_q;

endmodule

`default_nettype wire

// File: sv/ftn_sq_stage.sv
// One pipeline stage of the log2: square the mantissa and settle one fraction bit.
`default_nettype none

module ftn_sq_stage #(
	parameter int BIT = 15
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire ftn_pkg::log_t d,
	output ftn_pkg::log_t      q
);
	import ftn_pkg::*;

	logic [MANT_W:0]       sq;
	logic [LOG_FRAC_W-1:0] frac_nxt;
	logic [MANT_W-1:0]     mant_nxt;

	// Squaring and halving when the square reaches two
	always_comb begin
		sq       = square_q30(d.mant);
		frac_nxt = d.frac;
		frac_nxt[BIT] = sq[MANT_W];
		mant_nxt = sq[MANT_W] ? sq[MANT_W:1] : sq[MANT_W-1:0];
	end

	// Stage register: valid bit with its word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else begin
			q.valid <= d.valid;
			q.zero  <= d.zero;
			q.ipart <= d.ipart;
			q.frac  <= frac_nxt;
			q.mant  <= mant_nxt;
		end
	end

endmodule

`default_nettype wire

// File: sv/ftn_note_map.sv
// Back end: semitone offset, cents, rounding, saturation and note fields.
`default_nettype none

module ftn_note_map #(
	parameter int TOP_OCTAVE = ftn_pkg::TOP_OCTAVE_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire ftn_pkg::log_t                       d,
	input  wire logic [ftn_pkg::LOG_W-1:0]           log_ref,
	input  wire logic                                ref_zero,
	output logic                                     done,
	output logic [ftn_pkg::PC_W-1:0]                 semitone,
	output logic [ftn_pkg::OCT_W-1:0]                octave,
	output logic                                     sharp,
	output logic [ftn_pkg::MIDI_W-1:0]               midi_number,
	output logic signed [ftn_pkg::CENTS_W-1:0]       cents,
	output logic                                     out_of_range
);
	import ftn_pkg::*;

	localparam int TOP_IDX   = SEMITONES * (TOP_OCTAVE + 1) - 1;
	localparam int S_W       = LOG_W + 5;
	localparam int N_W       = S_W - LOG_FRAC_W;
	localparam int IDXS_W    = N_W + 1;
	// octave = idx/12 as (idx*171)>>11, exact for 8-bit indices
	localparam int OCT_RECIP = 171;
	localparam int OCT_SHIFT = 11;

	// Stage 18: log difference times twelve
	logic signed [LOG_W:0]   diff;
	logic signed [S_W-1:0]   dx;
	logic                    valid_s18, none_s18;
	logic signed [S_W-1:0]   s_s18;

	// Stage 19: semitone floor and raw cents
	logic [LOG_FRAC_W+CENTS_W-1:0] cprod;
	logic                    valid_s19, none_s19;
	logic signed [N_W-1:0]   n_s19;
	logic [CENTS_W-1:0]      craw_s19;

	// Stage 20: round up past half a semitone, saturate
	logic                    up;
	logic signed [IDXS_W-1:0] idx_full;
	logic signed [CENTS_W:0] cents_adj;
	logic [IDX_W-1:0]        idx_nxt;
	logic signed [CENTS_W-1:0] cents_nxt;
	logic                    oor_nxt;
	logic                    valid_s20;
	logic [IDX_W-1:0]        idx_s20;
	logic signed [CENTS_W-1:0] cents_s20;
	logic                    oor_s20;

	// Stage 21: octave and pitch class
	logic [2*IDX_W-1:0]      oprod;
	logic [OCT_W-1:0]        oct;
	logic [IDX_W-1:0]        pc_full;
	logic [PC_W-1:0]         pc;

	always_comb begin
		diff = $signed({1'b0, d.ipart, d.frac}) - $signed({1'b0, log_ref});
		dx   = S_W'(diff);
	end

	always_comb begin
		cprod = s_s18[LOG_FRAC_W-1:0] * (LOG_FRAC_W+CENTS_W)'(CENTS_PER_SEMI);
	end

	always_comb begin
		up        = craw_s19 > CENTS_W'(HALF_SEMI_CENTS);
		idx_full  = IDXS_W'(n_s19) + IDXS_W'(up) + IDXS_W'(A4_INDEX);
		cents_adj = up ? $signed({1'b0, craw_s19}) - $signed((CENTS_W+1)'(CENTS_PER_SEMI))
		               : $signed({1'b0, craw_s19});
		if (none_s19) begin
			idx_nxt   = IDX_W'(A4_INDEX);
			cents_nxt = '0;
			oor_nxt   = 1'b0;
		end else if (idx_full < $signed(IDXS_W'(0))) begin
			idx_nxt   = '0;
			cents_nxt = '0;
			oor_nxt   = 1'b1;
		end else if (idx_full > $signed(IDXS_W'(TOP_IDX))) begin
			idx_nxt   = IDX_W'(TOP_IDX);
			cents_nxt = '0;
			oor_nxt   = 1'b1;
		end else begin
			idx_nxt   = idx_full[IDX_W-1:0];
			cents_nxt = cents_adj[CENTS_W-1:0];
			oor_nxt   = 1'b0;
		end
	end

	always_comb begin
		oprod   = {{IDX_W{1'b0}}, idx_s20} * (2*IDX_W)'(OCT_RECIP);
		oct     = OCT_W'(oprod >> OCT_SHIFT);
		pc_full = idx_s20 - IDX_W'(oct) * IDX_W'(SEMITONES);
		pc      = pc_full[PC_W-1:0];
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s18 <= 1'b0;
			valid_s19 <= 1'b0;
			valid_s20 <= 1'b0;
			done      <= 1'b0;
		end else begin
			valid_s18 <= d.valid;
			valid_s19 <= valid_s18;
			valid_s20 <= valid_s19;
			done      <= valid_s20;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		none_s18     <= d.zero || ref_zero;
		s_s18        <= (dx <<< 3) + (dx <<< 2);
		none_s19     <= none_s18;
		n_s19        <= s_s18[S_W-1:LOG_FRAC_W];
		craw_s19     <= cprod[LOG_FRAC_W+CENTS_W-1:LOG_FRAC_W];
		idx_s20      <= idx_nxt;
		cents_s20    <= cents_nxt;
		oor_s20      <= oor_nxt;
		semitone     <= pc;
		octave       <= oct;
		sharp        <= pc inside {4'd1, 4'd3, 4'd6, 4'd8, 4'd10};
		midi_number  <= idx_s20 + MIDI_W'(SEMITONES);
		cents        <= cents_s20;
		out_of_range <= oor_s20;
	end

endmodule

`default_nettype wire

// File: sv/frequency_to_note.sv
// Top level: nearest equal-tempered note of a frequency, pipelined.
//
//  channel  | handshake              | word
//  ---------+------------------------+------------------------------------------
//  input    | start, busy            | frequency
//  config   | cfg_valid, cfg_ready   | reference_pitch
//  result   | done (one-cycle strobe)| semitone, octave, sharp, midi_number,
//           |                        | cents, out_of_range
//
// One word enters per cycle while busy is low; each passes through the normalise
// stage, sixteen squaring stages for the log2 fraction bits and four mapping stages.
// After reset and after each reference write, busy stays high while the log2 of the
// reference is formed one squaring per cycle.
// The receiver cannot stall; results leave on done without back-pressure.
`default_nettype none

module frequency_to_note #(
	parameter int TOP_OCTAVE = ftn_pkg::TOP_OCTAVE_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic [ftn_pkg::FREQ_W-1:0]        frequency,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [ftn_pkg::REF_W-1:0]         reference_pitch,
	output logic                                   done,
	output logic [ftn_pkg::PC_W-1:0]               semitone,
	output logic [ftn_pkg::OCT_W-1:0]              octave,
	output logic                                   sharp,
	output logic [ftn_pkg::MIDI_W-1:0]             midi_number,
	output logic signed [ftn_pkg::CENTS_W-1:0]     cents,
	output logic                                   out_of_range
);
	import ftn_pkg::*;

	localparam int LAT = 1 + LOG_FRAC_W + 4;

	logic                  accept;
	norm_t                 norm;
	log_t                  freq_s1;
	log_t                  chain [0:LOG_FRAC_W];
	logic [LOG_W-1:0]      log_ref;
	logic                  ref_zero;

	// Reference register and its log2
	ftn_log2_iter u_ref (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.reference_pitch (reference_pitch),
		.busy            (busy),
		.log_ref         (log_ref),
		.ref_zero        (ref_zero)
	);

	// Stage 1: capture and normalise the frequency
	assign accept = start && !busy;
	assign norm   = normalise(frequency);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_s1 <= '0;
		end else begin
			freq_s1.valid <= accept;
			freq_s1.zero  <= norm.zero;
			freq_s1.ipart <= norm.ipart;
			freq_s1.frac  <= '0;
			freq_s1.mant  <= norm.mant;
		end
	end

	assign chain[0] = freq_s1;

	// Stages 2..17: one fraction bit each, most significant first
	for (genvar k = 0; k < LOG_FRAC_W; k++) begin : g_sq
		ftn_sq_stage #(
			.BIT (LOG_FRAC_W - 1 - k)
		) u_sq (
			.clk    (clk),
			.arst_n (arst_n),
			.d      (chain[k]),
			.q      (chain[k+1])
		);
	end

	// Stages 18..21: note mapping
	ftn_note_map #(
		.TOP_OCTAVE (TOP_OCTAVE)
	) u_map (
		.clk          (clk),
		.arst_n       (arst_n),
		.d            (chain[LOG_FRAC_W]),
		.log_ref      (log_ref),
		.ref_zero     (ref_zero),
		.done         (done),
		.semitone     (semitone),
		.octave       (octave),
		.sharp        (sharp),
		.midi_number  (midi_number),
		.cents        (cents),
		.out_of_range (out_of_range)
	);

	// Checks
	a_cfg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> busy)
		else $error("reference write did not raise busy");

	a_lat_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LAT done)
		else $error("accepted word produced no result");

	a_lat_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LAT))
		else $error("result without an accepted word");

	a_sat_cents: assert property (@(posedge clk) disable iff (!arst_n)
		done && out_of_range |-> cents == '0 && midi_number != MIDI_W'(A4_INDEX + SEMITONES))
		else $error("saturated result with nonzero cents");

	a_fields: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> semitone < PC_W'(SEMITONES) && octave <= OCT_W'(TOP_OCTAVE))
		else $error("note fields out of range");

endmodule

`default_nettype wire
